[design/bmp24_pkg.sv]
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared types and constants for the 24-bit BMP stream pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp24_pkg;

  // Image size limits
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Header layout (byte positions in the file)
  localparam logic [31:0] HDR_MAGIC0_POS = 32'd0;
  localparam logic [31:0] HDR_MAGIC1_POS = 32'd1;
  localparam logic [31:0] HDR_OFFSET_POS = 32'd10;
  localparam logic [31:0] HDR_WIDTH_POS  = 32'd18;
  localparam logic [31:0] HDR_HEIGHT_POS = 32'd22;
  localparam logic [31:0] HDR_BPP_POS    = 32'd28;
  localparam logic [31:0] HDR_BYTES      = 32'd54;
  localparam logic [31:0] HDR_LAST_POS   = HDR_BYTES - 32'd1;

  localparam logic [7:0]  MAGIC_B      = 8'h42;
  localparam logic [7:0]  MAGIC_M      = 8'h4d;
  localparam logic [15:0] BPP_SUPPORTED = 16'd24;

  // Command queue between parser and converter
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Output buffer depth
  localparam int unsigned OUTB_DEPTH = 2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_PAD
  } phase_t;

  typedef enum logic [1:0] {
    ST_PIXEL     = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_BAD_DEPTH = 2'd2,
    ST_BAD_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FMT_RGB565 = 2'd0,
    FMT_RGB24  = 2'd1,
    FMT_RGB32  = 2'd2,
    FMT_SPARE  = 2'd3
  } dest_fmt_t;

  // One classified request from the parser
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    status_t     status;
    logic        last;
  } cmd_t;

  // One finished result
  typedef struct packed {
    logic [23:0] pixel_value;
    logic [11:0] column;
    logic [11:0] row;
    status_t     status;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

[design/bmp24_front.sv]
// ----------------------------------------------------------------------------
// bmp24_front
// Byte parser: checks the magic, captures header fields, skips to the pixel
// data, tracks rows, columns and padding, and issues pixel or error requests.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_front import bmp24_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] file_byte,
  input  wire logic       start_of_file,
  output cmd_t            cmd_o,
  output logic            cmd_push
);

  phase_t      phase_r,  phase_nxt;
  logic [31:0] pos_r,    pos_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] width_r,  width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [15:0] bpp_r,    bpp_nxt;
  logic [11:0] col_r,    col_nxt;
  logic [11:0] srow_r,   srow_nxt;
  logic [1:0]  comp_r,   comp_nxt;
  logic [15:0] asm_r,    asm_nxt;
  logic [1:0]  pad_r,    pad_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      offset_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      bpp_r    <= '0;
      col_r    <= '0;
      srow_r   <= '0;
      comp_r   <= '0;
      asm_r    <= '0;
      pad_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bpp_r    <= bpp_nxt;
      col_r    <= col_nxt;
      srow_r   <= srow_nxt;
      comp_r   <= comp_nxt;
      asm_r    <= asm_nxt;
      pad_r    <= pad_nxt;
    end
  end

  phase_t      ph;
  logic [31:0] p;
  logic [1:0]  off_lane, wid_lane, hgt_lane;
  logic        bpp_lane;
  logic        last_col, last_row;
  logic [1:0]  pad_dec;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    offset_nxt = offset_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bpp_nxt    = bpp_r;
    col_nxt    = col_r;
    srow_nxt   = srow_r;
    comp_nxt   = comp_r;
    asm_nxt    = asm_r;
    pad_nxt    = pad_r;
    cmd_push   = 1'b0;
    cmd_o      = '0;
    ph         = phase_r;
    p          = pos_r;
    off_lane   = 2'(pos_r - HDR_OFFSET_POS);
    wid_lane   = 2'(pos_r - HDR_WIDTH_POS);
    hgt_lane   = 2'(pos_r - HDR_HEIGHT_POS);
    bpp_lane   = 1'(pos_r - HDR_BPP_POS);
    last_col   = (({1'b0, col_r} + 13'd1) == width_r[12:0]);
    last_row   = (({1'b0, srow_r} + 13'd1) == height_r[12:0]);
    pad_dec    = pad_r - 2'd1;

    if (accept) begin
      // Restart: drop the current file, this byte is byte 0
      if (start_of_file) begin
        ph         = PH_HEADER;
        p          = '0;
        phase_nxt  = PH_HEADER;
        offset_nxt = '0;
        width_nxt  = '0;
        height_nxt = '0;
        bpp_nxt    = '0;
        col_nxt    = '0;
        srow_nxt   = '0;
        comp_nxt   = '0;
        asm_nxt    = '0;
        pad_nxt    = '0;
      end
      if (ph != PH_IDLE) begin
        pos_nxt = p + 32'd1;
      end

      unique case (ph)
        PH_IDLE: begin
        end
        PH_HEADER: begin
          if ((p == HDR_MAGIC0_POS && file_byte != MAGIC_B) ||
              (p == HDR_MAGIC1_POS && file_byte != MAGIC_M)) begin
            cmd_push      = 1'b1;
            cmd_o.status  = ST_BAD_MAGIC;
            cmd_o.last    = 1'b1;
            phase_nxt     = PH_IDLE;
          end
          if (p >= HDR_OFFSET_POS && p < HDR_OFFSET_POS + 32'd4) begin
            offset_nxt[{off_lane, 3'b000} +: 8] = file_byte;
          end
          if (p >= HDR_WIDTH_POS && p < HDR_WIDTH_POS + 32'd4) begin
            width_nxt[{wid_lane, 3'b000} +: 8] = file_byte;
          end
          if (p >= HDR_HEIGHT_POS && p < HDR_HEIGHT_POS + 32'd4) begin
            height_nxt[{hgt_lane, 3'b000} +: 8] = file_byte;
          end
          if (p >= HDR_BPP_POS && p < HDR_BPP_POS + 32'd2) begin
            bpp_nxt[{bpp_lane, 3'b000} +: 8] = file_byte;
          end
          if (p == HDR_LAST_POS) begin
            if (bpp_r != BPP_SUPPORTED) begin
              cmd_push     = 1'b1;
              cmd_o.status = ST_BAD_DEPTH;
              cmd_o.last   = 1'b1;
              phase_nxt    = PH_IDLE;
            end else if (width_r == '0 || width_r > 32'(MAX_WIDTH) ||
                         height_r == '0 || height_r > 32'(MAX_HEIGHT) ||
                         offset_r < HDR_BYTES) begin
              cmd_push     = 1'b1;
              cmd_o.status = ST_BAD_RANGE;
              cmd_o.last   = 1'b1;
              phase_nxt    = PH_IDLE;
            end else if (offset_r == HDR_BYTES) begin
              phase_nxt = PH_PIXELS;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (p + 32'd1 == offset_r) begin
            phase_nxt = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          if (comp_r < 2'd2) begin
            if (comp_r == 2'd0) begin
              asm_nxt[7:0] = file_byte;
            end else begin
              asm_nxt[15:8] = file_byte;
            end
            comp_nxt = comp_r + 2'd1;
          end else begin
            // Red byte completes the pixel
            comp_nxt     = '0;
            cmd_push     = 1'b1;
            cmd_o.blue   = asm_r[7:0];
            cmd_o.green  = asm_r[15:8];
            cmd_o.red    = file_byte;
            cmd_o.column = col_r;
            cmd_o.row    = height_r[11:0] - 12'd1 - srow_r;
            cmd_o.status = ST_PIXEL;
            cmd_o.last   = last_row && last_col;
            if (last_col) begin
              col_nxt  = '0;
              srow_nxt = srow_r + 12'd1;
              pad_nxt  = width_r[1:0];
              if (last_row) begin
                phase_nxt = PH_IDLE;
              end else if (width_r[1:0] != 2'd0) begin
                phase_nxt = PH_PAD;
              end
            end else begin
              col_nxt = col_r + 12'd1;
            end
          end
        end
        PH_PAD: begin
          pad_nxt = pad_dec;
          if (pad_dec == 2'd0) begin
            phase_nxt = PH_PIXELS;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  a_final_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && cmd_o.last |=> phase_r == PH_IDLE)
    else $error("parser not idle after final pixel or error");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAD |-> pad_r != 2'd0)
    else $error("padding phase with no padding left");

endmodule

`default_nettype wire

[design/bmp24_cmdq.sv]
// ----------------------------------------------------------------------------
// bmp24_cmdq
// Short request queue between the parser and the colour converter.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_cmdq import bmp24_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      din,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      head
);

  cmd_t                 mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_r;
  logic [CMDQ_AW-1:0]   rd_ptr_r;
  logic [CMDQ_CW-1:0]   cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CMDQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CMDQ_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CMDQ_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CMDQ_CW'(CMDQ_DEPTH))
    else $error("request queue count overflow");

  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[CMDQ_AW-1:0])
    else $error("request queue pointers disagree with count");

endmodule

`default_nettype wire

[design/bmp24_back.sv]
// ----------------------------------------------------------------------------
// bmp24_back
// Colour converter: turns queued requests into results in the selected
// format and holds them in a two-entry output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_back import bmp24_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] dest_format,
  input  cmd_t            q_head,
  input  wire logic       q_empty,
  output logic            q_pop,
  output res_t            res_o,
  output logic            res_empty,
  input  wire logic       res_pop
);

  res_t        ent_r [OUTB_DEPTH];
  logic        wr_r;
  logic        rd_r;
  logic [1:0]  cnt_r;
  res_t        conv;
  logic        do_pop;

  // Error requests carry zero colour, so both forms give zero there
  always_comb begin
    conv.column = q_head.column;
    conv.row    = q_head.row;
    conv.status = q_head.status;
    conv.last   = q_head.last;
    if (dest_format == FMT_RGB565) begin
      conv.pixel_value = {8'd0, q_head.red[7:3], q_head.green[7:2], q_head.blue[7:3]};
    end else begin
      conv.pixel_value = {q_head.red, q_head.green, q_head.blue};
    end
  end

  assign q_pop     = !q_empty && (cnt_r != 2'(OUTB_DEPTH));
  assign res_empty = (cnt_r == 2'd0);
  assign do_pop    = res_pop && !res_empty;
  assign res_o     = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (q_pop) begin
        wr_r <= ~wr_r;
      end
      if (do_pop) begin
        rd_r <= ~rd_r;
      end
      if (q_pop && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !q_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r[wr_r] <= conv;
    end
  end

  a_outb_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(OUTB_DEPTH) && ((wr_r ^ rd_r) == cnt_r[0]))
    else $error("output buffer count inconsistent");

endmodule

`default_nettype wire

[design/bmp24_stream_pixel_decoder_core.sv]
// ----------------------------------------------------------------------------
// bmp24_stream_pixel_decoder_core
// 24-bit BMP stream decoder: parses the header and bottom-up pixel rows and
// emits one converted pixel with its destination coordinates per BGR triple.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  in       in_push / in_full  in_file_byte[7:0], in_start_of_file
//  out      out_pop / out_empty out_pixel_value[23:0], out_column[11:0],
//                              out_row[11:0], out_status[1:0], out_last
//  cfg      cfg_valid/cfg_ready cfg_data[1:0] (dest_format)
//
//  While in_full is low, one file byte is taken every cycle; header, skip and
//  padding bytes give no result unless a header check fails, and the red byte
//  of each pixel gives one. A result passes through the request queue and
//  then the output buffer before it shows on the out ports; while results
//  wait and out_pop is high, results leave at one per cycle.
//  in_full rises only when the four-entry request queue is full, which
//  happens when out_pop is held low.
//  Reset is synchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_stream_pixel_decoder_core import bmp24_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_file_byte,
  input  wire logic        in_start_of_file,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [23:0]      out_pixel_value,
  output logic [11:0]      out_column,
  output logic [11:0]      out_row,
  output logic [1:0]       out_status,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data
);

  logic [1:0] fmt_r;
  cmd_t       cmd;
  logic       cmd_push;
  cmd_t       q_head;
  logic       q_empty;
  logic       q_pop;
  res_t       res;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGB565;
    end else if (cfg_valid && cfg_ready) begin
      fmt_r <= cfg_data;
    end
  end

  bmp24_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .file_byte     (in_file_byte),
    .start_of_file (in_start_of_file),
    .cmd_o         (cmd),
    .cmd_push      (cmd_push)
  );

  bmp24_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd),
    .full  (in_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  bmp24_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .dest_format (fmt_r),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .res_o       (res),
    .res_empty   (out_empty),
    .res_pop     (out_pop)
  );

  assign out_pixel_value = res.pixel_value;
  assign out_column      = res.column;
  assign out_row         = res.row;
  assign out_status      = res.status;
  assign out_last        = res.last;

endmodule

`default_nettype wire
